@@ hdl/nearest_obstacle_steer_decider_core_assert.svh @@
// Assertion macros shared by the checker of the obstacle steer decider.
// Each macro expands to one labeled concurrent assertion on a clock and a reset.
`ifndef NEAREST_OBSTACLE_STEER_DECIDER_CORE_ASSERT_SVH
`define NEAREST_OBSTACLE_STEER_DECIDER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define NOSD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nosd assertion failed");

// Next-cycle implication, disabled while reset is high.
`define NOSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nosd assertion failed");

`endif

@@ hdl/nosd_pkg.sv @@
// Shared types and constants of the nearest obstacle steer decider.
// Used by every module of the block; depends on nothing.
`default_nettype none

package nosd_pkg;

   localparam int COUNT_BITS_DEFAULT  = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int MM_BITS             = 16;
   localparam int CFG_MM_BITS         = 15;
   localparam int PWM_BITS            = 12;
   localparam int KEPT_BITS           = 16;
   localparam int SENTINEL_MARGIN     = 100;
   localparam logic signed [MM_BITS-1:0] MM_MAX = 16'sh7FFF;

   // Register reset values
   localparam logic [CFG_MM_BITS-1:0] DETECT_RANGE_RESET = 15'd1000;
   localparam logic [CFG_MM_BITS-1:0] BACK_OFF_RESET     = 15'd600;
   localparam logic [CFG_MM_BITS-1:0] HALF_WIDTH_RESET   = 15'd250;
   localparam logic [PWM_BITS-1:0]    STEER_LEFT_RESET   = 12'd1890;
   localparam logic [PWM_BITS-1:0]    STEER_RIGHT_RESET  = 12'd991;
   localparam logic [PWM_BITS-1:0]    STEER_STRAIGHT_RESET = 12'd1370;
   localparam logic [PWM_BITS-1:0]    THROTTLE_FWD_RESET = 12'd1530;
   localparam logic [PWM_BITS-1:0]    THROTTLE_BACK_RESET = 12'd1375;

   typedef enum logic [2:0] {
      REG_DETECT_RANGE     = 3'd0,
      REG_BACK_OFF         = 3'd1,
      REG_HALF_WIDTH       = 3'd2,
      REG_STEER_LEFT       = 3'd3,
      REG_STEER_RIGHT      = 3'd4,
      REG_STEER_STRAIGHT   = 3'd5,
      REG_THROTTLE_FORWARD = 3'd6,
      REG_THROTTLE_BACK    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [MM_BITS-1:0] point_x_mm;
      logic signed [MM_BITS-1:0] point_y_mm;
      logic signed [MM_BITS-1:0] point_z_mm;
      logic                      point_valid;
      logic                      last_point;
   } req_payload_type;

   typedef struct packed {
      logic [PWM_BITS-1:0]       steering_cmd;
      logic [PWM_BITS-1:0]       throttle_cmd;
      logic signed [MM_BITS-1:0] nearest_x_mm;
      logic signed [MM_BITS-1:0] nearest_y_mm;
      logic signed [MM_BITS-1:0] nearest_z_mm;
      logic [KEPT_BITS-1:0]      kept_count;
   } rsp_payload_type;

   typedef struct packed {
      logic [CFG_MM_BITS-1:0] detect_range_mm;
      logic [CFG_MM_BITS-1:0] back_off_mm;
      logic [CFG_MM_BITS-1:0] half_width_mm;
      logic [PWM_BITS-1:0]    steer_left_pwm;
      logic [PWM_BITS-1:0]    steer_right_pwm;
      logic [PWM_BITS-1:0]    steer_straight_pwm;
      logic [PWM_BITS-1:0]    throttle_forward_pwm;
      logic [PWM_BITS-1:0]    throttle_back_pwm;
   } cfg_type;

   // One classified point waiting for the back end
   typedef struct packed {
      logic signed [MM_BITS-1:0] x_mm;
      logic signed [MM_BITS-1:0] y_mm;
      logic signed [MM_BITS-1:0] z_mm;
      logic                      keep;
      logic                      last;
   } qentry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

@@ hdl/nosd_csr.sv @@
// Configuration register file of the obstacle steer decider.
// Depends on nosd_pkg for the register layout, indexes and reset values.
`default_nettype none

module nosd_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  nosd_pkg::reg_index_type csr_index,
   input  logic [nosd_pkg::CFG_MM_BITS-1:0] csr_wdata,
   output nosd_pkg::cfg_type      cfg
);
   import nosd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Write one register; narrower registers take the low bits
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_DETECT_RANGE:     cfg_in.detect_range_mm      = csr_wdata;
            REG_BACK_OFF:         cfg_in.back_off_mm          = csr_wdata;
            REG_HALF_WIDTH:       cfg_in.half_width_mm        = csr_wdata;
            REG_STEER_LEFT:       cfg_in.steer_left_pwm       = csr_wdata[PWM_BITS-1:0];
            REG_STEER_RIGHT:      cfg_in.steer_right_pwm      = csr_wdata[PWM_BITS-1:0];
            REG_STEER_STRAIGHT:   cfg_in.steer_straight_pwm   = csr_wdata[PWM_BITS-1:0];
            REG_THROTTLE_FORWARD: cfg_in.throttle_forward_pwm = csr_wdata[PWM_BITS-1:0];
            REG_THROTTLE_BACK:    cfg_in.throttle_back_pwm    = csr_wdata[PWM_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detect_range_mm      <= DETECT_RANGE_RESET;
         cfg_ff.back_off_mm          <= BACK_OFF_RESET;
         cfg_ff.half_width_mm        <= HALF_WIDTH_RESET;
         cfg_ff.steer_left_pwm       <= STEER_LEFT_RESET;
         cfg_ff.steer_right_pwm      <= STEER_RIGHT_RESET;
         cfg_ff.steer_straight_pwm   <= STEER_STRAIGHT_RESET;
         cfg_ff.throttle_forward_pwm <= THROTTLE_FWD_RESET;
         cfg_ff.throttle_back_pwm    <= THROTTLE_BACK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ hdl/nosd_front.sv @@
// Front end: accepts points, runs the box test and queues the ones that matter.
// Depends on nosd_pkg for the payload, queue entry and status types.
`default_nettype none

module nosd_front (
   input  nosd_pkg::cfg_type          cfg,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  nosd_pkg::req_payload_type  req_payload,
   input  nosd_pkg::queue_status_type qstat,
   output logic                       push,
   output nosd_pkg::qentry_type       push_entry
);
   import nosd_pkg::*;

   logic signed [MM_BITS:0]   x_ext;
   logic signed [MM_BITS:0]   half_pos;
   logic signed [MM_BITS:0]   half_neg;
   logic signed [MM_BITS-1:0] range_ext;
   logic                      in_box;
   logic                      accept;

   // Hold the source off while the queue is full
   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;

   // Box test: depth within range, above the horizon, inside the lateral band
   always_comb begin
      x_ext     = {req_payload.point_x_mm[MM_BITS-1], req_payload.point_x_mm};
      half_pos  = {2'b00, cfg.half_width_mm};
      half_neg  = -half_pos;
      range_ext = {1'b0, cfg.detect_range_mm};
      in_box    = req_payload.point_valid
                  && ($signed(req_payload.point_z_mm) <= range_ext)
                  && req_payload.point_y_mm[MM_BITS-1]
                  && (x_ext >= half_neg)
                  && (x_ext <= half_pos);
   end

   // Drop points that are neither kept nor close the cloud
   always_comb begin
      push_entry.x_mm = req_payload.point_x_mm;
      push_entry.y_mm = req_payload.point_y_mm;
      push_entry.z_mm = req_payload.point_z_mm;
      push_entry.keep = in_box;
      push_entry.last = req_payload.last_point;
      push            = accept && (in_box || req_payload.last_point);
   end

endmodule

`default_nettype wire

@@ hdl/nosd_queue.sv @@
// Short FIFO of classified points between the front and back ends.
// Depends on nosd_pkg for the entry and status types.
`default_nettype none

module nosd_queue #(
   parameter int DEPTH = nosd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  nosd_pkg::qentry_type       push_entry,
   input  logic                       pop,
   output nosd_pkg::qentry_type       head,
   output nosd_pkg::queue_status_type qstat
);
   import nosd_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   qentry_type          slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head        = slot_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == CNT_FULL);
   assign qstat.empty = (count_ff == '0);

endmodule

`default_nettype wire

@@ hdl/nosd_back.sv @@
// Back end: tracks the nearest kept point and the count, decides on the last point.
// Depends on nosd_pkg for the configuration, entry and result types.
`default_nettype none

module nosd_back #(
   parameter int COUNT_BITS = nosd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  nosd_pkg::cfg_type          cfg,
   input  nosd_pkg::qentry_type       head,
   input  nosd_pkg::queue_status_type qstat,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output nosd_pkg::rsp_payload_type  rsp_payload
);
   import nosd_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic signed [MM_BITS-1:0] best_x_ff, best_y_ff, best_z_ff;
   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_payload_ff, rsp_payload_in;

   logic                      out_free;
   logic                      take_best;
   logic signed [MM_BITS-1:0] cur_x, cur_y, cur_z;
   logic [COUNT_BITS-1:0]     cur_count;
   logic [MM_BITS-1:0]        sentinel_sum;
   logic signed [MM_BITS-1:0] sentinel;
   logic signed [MM_BITS-1:0] nx, ny, nz;
   logic signed [MM_BITS-1:0] range_ext, back_ext;
   logic                      in_range, far;
   logic [KEPT_BITS-1:0]      kept;

   // Pop a kept point at once; a closing point waits for the output slot
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = !qstat.empty && (!head.last || out_free);

   // Fold the popped point into the running nearest point and count
   always_comb begin
      take_best = pop && head.keep
                  && ((count_ff == '0) || ($signed(head.z_mm) < best_z_ff));
      cur_x     = take_best ? head.x_mm : best_x_ff;
      cur_y     = take_best ? head.y_mm : best_y_ff;
      cur_z     = take_best ? head.z_mm : best_z_ff;
      cur_count = count_ff;
      if (pop && head.keep && (count_ff != COUNT_MAX)) begin
         cur_count = count_ff + 1'b1;
      end
   end

   // Saturate the count into the result field width
   generate
      if (COUNT_BITS > KEPT_BITS) begin : g_kept_sat
         assign kept = (|cur_count[COUNT_BITS-1:KEPT_BITS]) ? {KEPT_BITS{1'b1}}
                                                             : cur_count[KEPT_BITS-1:0];
      end else begin : g_kept_ext
         assign kept = KEPT_BITS'(cur_count);
      end
   endgenerate

   // Empty cloud reports range plus margin, capped at the largest depth
   always_comb begin
      sentinel_sum = {1'b0, cfg.detect_range_mm} + MM_BITS'(SENTINEL_MARGIN);
      sentinel     = sentinel_sum[MM_BITS-1] ? MM_MAX : $signed(sentinel_sum);
      if (cur_count != '0) begin
         nx = cur_x;
         ny = cur_y;
         nz = cur_z;
      end else begin
         nx = sentinel;
         ny = sentinel;
         nz = sentinel;
      end
   end

   // Steering and throttle decision on the nearest point
   always_comb begin
      range_ext = {1'b0, cfg.detect_range_mm};
      back_ext  = {1'b0, cfg.back_off_mm};
      in_range  = (nz <= range_ext);
      far       = (nz > back_ext);

      rsp_payload_in = rsp_payload_ff;
      priority if (!nx[MM_BITS-1] && (nx != '0) && in_range) begin
         rsp_payload_in.steering_cmd = far ? cfg.steer_left_pwm : cfg.steer_right_pwm;
      end else if (nx[MM_BITS-1] && in_range) begin
         rsp_payload_in.steering_cmd = far ? cfg.steer_right_pwm : cfg.steer_left_pwm;
      end else begin
         rsp_payload_in.steering_cmd = cfg.steer_straight_pwm;
      end
      rsp_payload_in.throttle_cmd = far ? cfg.throttle_forward_pwm : cfg.throttle_back_pwm;
      rsp_payload_in.nearest_x_mm = nx;
      rsp_payload_in.nearest_y_mm = ny;
      rsp_payload_in.nearest_z_mm = nz;
      rsp_payload_in.kept_count   = kept;
   end

   // Load the output slot on a closing point, drain it when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      count_in     = cur_count;
      if (pop && head.last) begin
         rsp_valid_in = 1'b1;
         count_in     = '0;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers; a zero count marks the nearest point as unset
   always_ff @(posedge clock) begin
      if (take_best) begin
         best_x_ff <= head.x_mm;
         best_y_ff <= head.y_mm;
         best_z_ff <= head.z_mm;
      end
      if (pop && head.last) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

@@ hdl/nearest_obstacle_steer_decider_core.sv @@
// Top level of the nearest obstacle steer decider.
// Depends on nosd_pkg, nosd_csr, nosd_front, nosd_queue and nosd_back.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------
//   req     | in        | req_valid/req_stall| req_payload_type
//   rsp     | out       | rsp_valid/rsp_stall| rsp_payload_type
//   csr     | in        | csr_we             | csr_index, csr_wdata
//
// One point per cycle while the queue has room: the box test runs in the front end in the
// cycle of acceptance; the back end folds one queued point per cycle into its tracker
// unless a last point is held. A last point is queued, then loaded into the output slot.
// Reset clears the queue, the tracker count, the output slot and loads register defaults.
// req_stall rises only while the point queue (QUEUE_DEPTH entries) is full; rsp_stall
// holds back only a last point, other points keep draining behind a waiting result.
`default_nettype none

module nearest_obstacle_steer_decider_core #(
   parameter int COUNT_BITS  = nosd_pkg::COUNT_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = nosd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  nosd_pkg::req_payload_type        req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output nosd_pkg::rsp_payload_type        rsp_payload,
   input  logic                             csr_we,
   input  nosd_pkg::reg_index_type          csr_index,
   input  logic [nosd_pkg::CFG_MM_BITS-1:0] csr_wdata
);
   import nosd_pkg::*;

   cfg_type          cfg;
   queue_status_type qstat;
   qentry_type       push_entry;
   qentry_type       head;
   logic             push;
   logic             pop;

   nosd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   nosd_front u_front (
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .qstat       (qstat),
      .push        (push),
      .push_entry  (push_entry)
   );

   nosd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   nosd_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .head        (head),
      .qstat       (qstat),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

@@ hdl/nosd_checker.sv @@
// Port-level checker of the obstacle steer decider, bound to the top level.
// Depends on nosd_pkg and the assertion macros header.
`default_nettype none

`include "nearest_obstacle_steer_decider_core_assert.svh"

module nosd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input nosd_pkg::rsp_payload_type rsp_payload
);
   import nosd_pkg::*;

   // A stalled result stays offered
   `NOSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // A stalled result keeps its fields
   `NOSD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload))

   // No result right after reset
   `NOSD_ASSERT_NOW(a_rsp_after_reset, clock, reset, $past(reset), !rsp_valid)

   // An empty cloud reports the same sentinel on all three coordinates
   `NOSD_ASSERT_NOW(a_empty_sentinel, clock, reset, rsp_valid && (rsp_payload.kept_count == '0), (rsp_payload.nearest_x_mm == rsp_payload.nearest_z_mm) && (rsp_payload.nearest_y_mm == rsp_payload.nearest_z_mm))

endmodule

bind nearest_obstacle_steer_decider_core nosd_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

@@ tb/steer_decision_checker.sv @@
// Checker for the nearest obstacle steer decider: folds each accepted point into its
// own nearest-point tracker and compares every emitted decision field by field.
// Depends on nosd_pkg for the payload, register index and configuration types.
`default_nettype none

module steer_decision_checker
   import nosd_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_payload_type        req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_payload_type        rsp_payload,
   input  logic                   csr_we,
   input  reg_index_type          csr_index,
   input  logic [CFG_MM_BITS-1:0] csr_wdata,
   output int                     fail_count,
   output int                     pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint TALLY_MAX = (longint'(1) << COUNT_BITS) - 1;

   cfg_type         regs;
   int              best_x;
   int              best_y;
   int              best_z;
   longint          kept_tally;
   rsp_payload_type decision_queue[$];
   int              failures = 0;

   task automatic check_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, actual %0d", name, want_v, got_v);
         failures++;
      end
   endtask

   always @(posedge clock) begin : watch
      int              x;
      int              y;
      int              z;
      int              depth_limit;
      int              back_limit;
      int              half_span;
      int              nx;
      int              ny;
      int              nz;
      rsp_payload_type want;
      if (reset) begin
         regs.detect_range_mm      = DETECT_RANGE_RESET;
         regs.back_off_mm          = BACK_OFF_RESET;
         regs.half_width_mm        = HALF_WIDTH_RESET;
         regs.steer_left_pwm       = STEER_LEFT_RESET;
         regs.steer_right_pwm      = STEER_RIGHT_RESET;
         regs.steer_straight_pwm   = STEER_STRAIGHT_RESET;
         regs.throttle_forward_pwm = THROTTLE_FWD_RESET;
         regs.throttle_back_pwm    = THROTTLE_BACK_RESET;
         kept_tally = 0;
         decision_queue.delete();
      end else begin
         // retire a decision against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (decision_queue.size() == 0) begin
               $error("decision emitted with no last point pending");
               failures++;
            end else begin
               want = decision_queue.pop_front();
               check_field("steering_cmd", want.steering_cmd, rsp_payload.steering_cmd);
               check_field("throttle_cmd", want.throttle_cmd, rsp_payload.throttle_cmd);
               check_field("nearest_x_mm", $signed(want.nearest_x_mm),
                           $signed(rsp_payload.nearest_x_mm));
               check_field("nearest_y_mm", $signed(want.nearest_y_mm),
                           $signed(rsp_payload.nearest_y_mm));
               check_field("nearest_z_mm", $signed(want.nearest_z_mm),
                           $signed(rsp_payload.nearest_z_mm));
               check_field("kept_count", want.kept_count, rsp_payload.kept_count);
            end
         end

         // register writes, PWM registers keep their low 12 bits
         if (csr_we) begin
            case (csr_index)
               REG_DETECT_RANGE:     regs.detect_range_mm      = csr_wdata;
               REG_BACK_OFF:         regs.back_off_mm          = csr_wdata;
               REG_HALF_WIDTH:       regs.half_width_mm        = csr_wdata;
               REG_STEER_LEFT:       regs.steer_left_pwm       = csr_wdata[PWM_BITS-1:0];
               REG_STEER_RIGHT:      regs.steer_right_pwm      = csr_wdata[PWM_BITS-1:0];
               REG_STEER_STRAIGHT:   regs.steer_straight_pwm   = csr_wdata[PWM_BITS-1:0];
               REG_THROTTLE_FORWARD: regs.throttle_forward_pwm = csr_wdata[PWM_BITS-1:0];
               REG_THROTTLE_BACK:    regs.throttle_back_pwm    = csr_wdata[PWM_BITS-1:0];
               default: ;
            endcase
         end

         // fold an accepted point into the tracker
         if (req_valid && !req_stall) begin
            x = $signed(req_payload.point_x_mm);
            y = $signed(req_payload.point_y_mm);
            z = $signed(req_payload.point_z_mm);
            depth_limit = regs.detect_range_mm;
            back_limit  = regs.back_off_mm;
            half_span   = regs.half_width_mm;
            if (req_payload.point_valid && z <= depth_limit && y < 0 &&
                x >= -half_span && x <= half_span) begin
               // first kept point always wins, a tie keeps the earlier one
               if (kept_tally == 0 || z < best_z) begin
                  best_x = x;
                  best_y = y;
                  best_z = z;
               end
               if (kept_tally < TALLY_MAX) kept_tally++;
            end
            if (req_payload.last_point) begin
               if (kept_tally != 0) begin
                  nx = best_x;
                  ny = best_y;
                  nz = best_z;
               end else begin
                  // empty cloud reports the capped sentinel everywhere
                  nz = depth_limit + SENTINEL_MARGIN;
                  if (nz > MM_MAX) nz = MM_MAX;
                  nx = nz;
                  ny = nz;
               end
               if (nx > 0 && nz <= depth_limit) begin
                  want.steering_cmd = (nz > back_limit) ? regs.steer_left_pwm
                                                        : regs.steer_right_pwm;
               end else if (nx < 0 && nz <= depth_limit) begin
                  want.steering_cmd = (nz > back_limit) ? regs.steer_right_pwm
                                                        : regs.steer_left_pwm;
               end else begin
                  want.steering_cmd = regs.steer_straight_pwm;
               end
               want.throttle_cmd = (nz > back_limit) ? regs.throttle_forward_pwm
                                                     : regs.throttle_back_pwm;
               want.nearest_x_mm = nx[MM_BITS-1:0];
               want.nearest_y_mm = ny[MM_BITS-1:0];
               want.nearest_z_mm = nz[MM_BITS-1:0];
               want.kept_count   = (kept_tally > 65535) ? {KEPT_BITS{1'b1}}
                                                        : kept_tally[KEPT_BITS-1:0];
               decision_queue.insert(decision_queue.size(), want);
               kept_tally = 0;
            end
         end
      end
      fail_count    <= failures;
      pending_count <= decision_queue.size();
   end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Top of the steer decider testbench: clock, reset, point and register stimulus and verdict.
// Depends on nosd_pkg, nearest_obstacle_steer_decider_core and steer_decision_checker.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import nosd_pkg::*;

   typedef logic [CFG_MM_BITS-1:0] csr_word_type;
   typedef csr_word_type csr_bank_type [8];
   typedef enum int {BANK_DEFAULTS, BANK_ZEROS, BANK_MAX, BANK_RANDOM} bank_style_type;

   localparam int CYCLE_LIMIT   = 200_000;
   localparam int DRAIN_CYCLES  = 16;
   localparam int PHASE_ITEMS   = 150;
   localparam int NUM_PHASES    = 8;
   localparam int FLOOD_POINTS  = 120;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_we      = 1'b0;
   reg_index_type          csr_index   = REG_DETECT_RANGE;
   logic [CFG_MM_BITS-1:0] csr_wdata   = '0;

   int fail_count;
   int pending_count;
   int gap_pct     = 0;
   int stall_pct   = 0;
   int cycle_count = 0;
   int shape_range = DETECT_RANGE_RESET;
   int shape_half  = HALF_WIDTH_RESET;
   int cloud_left  = 0;

   int             gap_table[4]   = '{0, 84, 0, 27};
   int             stall_table[4] = '{0, 0, 84, 27};
   bank_style_type phase_style[NUM_PHASES] = '{BANK_DEFAULTS, BANK_ZEROS, BANK_RANDOM,
      BANK_MAX, BANK_RANDOM, BANK_RANDOM, BANK_ZEROS, BANK_RANDOM};

   nearest_obstacle_steer_decider_core i_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_payload,
      .rsp_valid, .rsp_stall, .rsp_payload,
      .csr_we, .csr_index, .csr_wdata
   );

   steer_decision_checker i_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_payload,
      .rsp_valid, .rsp_stall, .rsp_payload,
      .csr_we, .csr_index, .csr_wdata,
      .fail_count, .pending_count
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic req_payload_type make_point(input int x, input int y, input int z,
                                                  input bit valid, input bit last);
      req_payload_type p;
      p.point_x_mm  = x[MM_BITS-1:0];
      p.point_y_mm  = y[MM_BITS-1:0];
      p.point_z_mm  = z[MM_BITS-1:0];
      p.point_valid = valid;
      p.last_point  = last;
      return p;
   endfunction

   function automatic csr_bank_type pick_bank(input bank_style_type style);
      csr_bank_type b;
      int           r;
      for (int i = 0; i < 8; i++) begin
         // PWM words sometimes carry stray upper bits
         r = ($urandom_range(3) == 0) ? $urandom_range(15'h7FFF) : $urandom_range(12'hFFF);
         b[i] = r[CFG_MM_BITS-1:0];
      end
      case (style)
         BANK_DEFAULTS: begin
            b[REG_DETECT_RANGE]     = DETECT_RANGE_RESET;
            b[REG_BACK_OFF]         = BACK_OFF_RESET;
            b[REG_HALF_WIDTH]       = HALF_WIDTH_RESET;
            b[REG_STEER_LEFT]       = STEER_LEFT_RESET;
            b[REG_STEER_RIGHT]      = STEER_RIGHT_RESET;
            b[REG_STEER_STRAIGHT]   = STEER_STRAIGHT_RESET;
            b[REG_THROTTLE_FORWARD] = THROTTLE_FWD_RESET;
            b[REG_THROTTLE_BACK]    = THROTTLE_BACK_RESET;
         end
         BANK_ZEROS: begin
            b[REG_DETECT_RANGE]   = '0;
            b[REG_BACK_OFF]       = '0;
            b[REG_HALF_WIDTH]     = '0;
            b[REG_STEER_STRAIGHT] = '0;
         end
         BANK_MAX: begin
            b[REG_DETECT_RANGE]     = '1;
            b[REG_BACK_OFF]         = ($urandom_range(1) == 0) ? '1 : 15'd16000;
            b[REG_HALF_WIDTH]       = '1;
            b[REG_STEER_LEFT]       = '1;
            b[REG_THROTTLE_FORWARD] = 15'h0FFF;
         end
         default: begin
            r = $urandom_range(3000, 200);
            b[REG_DETECT_RANGE] = r[CFG_MM_BITS-1:0];
            r = $urandom_range(r + 200);
            b[REG_BACK_OFF] = r[CFG_MM_BITS-1:0];
            r = $urandom_range(1000, 50);
            b[REG_HALF_WIDTH] = r[CFG_MM_BITS-1:0];
         end
      endcase
      return b;
   endfunction

   task automatic load_config(input csr_bank_type bank);
      reg_index_type r;
      r = r.first();
      do begin
         csr_we    <= 1'b1;
         csr_index <= r;
         csr_wdata <= bank[r];
         @(posedge clock);
         r = r.next();
      end while (r != r.first());
      csr_we <= 1'b0;
      shape_range = bank[REG_DETECT_RANGE];
      shape_half  = bank[REG_HALF_WIDTH];
   endtask

   // hold the item until accepted, with random sender gaps before it
   task automatic send_point(input req_payload_type p);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
   endtask

   // pause until every decision is out and the point queue has emptied
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int items);
      req_payload_type p;
      repeat (items) begin
         if ($urandom_range(9) == 0) begin
            // noise: any bit pattern
            p = make_point($urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                           $urandom_range(16'hFFFF), $urandom_range(1), $urandom_range(1));
         end else begin
            // points clustered around the box edges
            p = make_point($urandom_range(2 * shape_half + 100) - shape_half - 50,
                           $urandom_range(300) - 250,
                           $urandom_range(shape_range + 300) - 200,
                           ($urandom_range(15) != 0), (cloud_left == 0));
         end
         send_point(p);
         if (p.last_point) begin
            case ($urandom_range(9))
               0:       cloud_left = 0;
               9:       cloud_left = $urandom_range(60, 20);
               default: cloud_left = $urandom_range(8, 1);
            endcase
         end else if (cloud_left > 0) begin
            cloud_left--;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty cloud closed by an invalid point
      send_point(make_point(1, 2, 3, 1'b0, 1'b1));
      // one point per cloud: each steering branch and both throttles
      send_point(make_point(100, -5, 800, 1'b1, 1'b1));
      send_point(make_point(100, -5, 500, 1'b1, 1'b1));
      send_point(make_point(-100, -5, 800, 1'b1, 1'b1));
      send_point(make_point(-100, -5, 600, 1'b1, 1'b1));
      send_point(make_point(0, -5, 700, 1'b1, 1'b1));
      // box edges, extremes, a tie and a skipped point
      send_point(make_point(250, -1, 1000, 1'b1, 1'b0));
      send_point(make_point(251, -1, 10, 1'b1, 1'b0));
      send_point(make_point(-250, -1, 900, 1'b1, 1'b0));
      send_point(make_point(-251, -1, 10, 1'b1, 1'b0));
      send_point(make_point(10, 0, 10, 1'b1, 1'b0));
      send_point(make_point(10, -1, 1001, 1'b1, 1'b0));
      send_point(make_point(5, -32768, -32768, 1'b1, 1'b0));
      send_point(make_point(7, -3, -32768, 1'b1, 1'b0));
      send_point(make_point(1, -1, -5, 1'b0, 1'b0));
      send_point(make_point(32767, 32767, 32767, 1'b1, 1'b1));
      // kept points, then an invalid last point still closes the cloud
      send_point(make_point(-32768, -1, 0, 1'b1, 1'b0));
      send_point(make_point(-20, -1, 300, 1'b1, 1'b0));
      send_point(make_point(-1, -1, -1, 1'b0, 1'b1));
      drain();

      // a wide box that keeps nearly every point
      load_config(pick_bank(BANK_MAX));
      repeat (FLOOD_POINTS) begin
         send_point(make_point($urandom_range(16'hFFFF), -1 - int'($urandom_range(99)),
                               $urandom_range(16'hFFFF), 1'b1, 1'b0));
      end
      send_point(make_point(-7, -1, 40, 1'b0, 1'b1));
      // capped sentinel, then a first kept point at the sentinel depth
      send_point(make_point(0, -1, 0, 1'b0, 1'b1));
      send_point(make_point(3, -1, 32767, 1'b1, 1'b1));
      drain();

      // random phases; clouds run across phase boundaries
      for (int k = 0; k < NUM_PHASES; k++) begin
         gap_pct   = gap_table[k % 4];
         stall_pct = stall_table[k % 4];
         load_config(pick_bank(phase_style[k]));
         run_phase(PHASE_ITEMS);
         drain();
      end

      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
